FILE: hdl/fcca_pkg.sv
package fcca_pkg;

   // field widths
   localparam int OP_W       = 2;
   localparam int FAT_W      = 16;
   localparam int STATUS_W   = 2;
   localparam int N_W        = 13;
   localparam int FREE_W     = 17;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 17;

   // operation codes
   localparam logic [OP_W-1:0] OP_READ  = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
   localparam logic [OP_W-1:0] OP_ALLOC = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_RANGE     = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_BAD_LINK  = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_N_ENTRIES    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_INITIAL_FREE = 1'b1;

   localparam logic [FAT_W-1:0]  END_OF_CHAIN    = 16'hFFFF;
   localparam logic [FREE_W-1:0] FREE_UNKNOWN    = 17'h10000;
   localparam logic [N_W-1:0]    N_ENTRIES_RESET = 13'd4096;

endpackage

FILE: hdl/fcca_ram.sv
module fcca_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // registered read; data holds until the next read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: hdl/fat16_cluster_chain_allocator_core.sv
// FAT16 cluster chain allocator. The FAT lives in a single simple dual-port RAM of
// MAX_ENTRIES 16-bit entries (one write, one registered read port). After reset the
// block clears the table, one entry a cycle, and accepts no beat until that pass is
// done; CSR writes are taken throughout. One request is worked at a time. An
// allocation reads the table one entry per cycle through the RAM read port and visits
// at most n_entries - 2 entries; a new chain on a table with no cluster to visit
// answers full without a scan. The result sits in an output register, so the next
// request beat is accepted while the previous response beat still waits.
module fat16_cluster_chain_allocator_core #(
   parameter int MAX_ENTRIES = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   // request
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [fcca_pkg::OP_W-1:0]          req_op,
   input  logic [fcca_pkg::FAT_W-1:0]         req_cluster,
   input  logic [fcca_pkg::FAT_W-1:0]         req_value,
   // response
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [fcca_pkg::STATUS_W-1:0]      rsp_status,
   output logic [fcca_pkg::FAT_W-1:0]         rsp_result_cluster,
   output logic [fcca_pkg::FREE_W-1:0]        rsp_free_count,
   output logic                               rsp_info_changed,
   // configuration
   input  logic                               csr_we,
   input  logic [fcca_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fcca_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import fcca_pkg::*;

   localparam int AW = $clog2(MAX_ENTRIES);

   typedef enum logic [3:0] {
      CLEAR, IDLE, DECODE, RD_WAIT, LINK_WAIT, SCAN, WR_EOC, WR_LINK, RESP
   } state_type;

   state_type state_ff;

   // control / config state
   logic [AW-1:0]       clr_ff;
   logic [N_W-1:0]      n_entries_ff;
   logic [FREE_W-1:0]   free_ff;
   logic                dirty_ff;
   logic [FAT_W-1:0]    last_alloc_ff;

   // request latch
   logic [OP_W-1:0]     op_ff;
   logic [FAT_W-1:0]    cl_ff;
   logic [FAT_W-1:0]    value_ff;

   // scan pipeline: cur is the next address to issue, pend is the entry now on rdata
   logic [FAT_W-1:0]    start_ff;
   logic [FAT_W-1:0]    cur_ff;
   logic                issue_ff;
   logic                pend_ff;
   logic [FAT_W-1:0]    pend_addr_ff;
   logic                pend_last_ff;
   logic [FAT_W-1:0]    found_ff;

   // pending result and output register
   logic [STATUS_W-1:0] status_ff;
   logic [FAT_W-1:0]    res_ff;
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [FAT_W-1:0]    rsp_res_ff;
   logic [FREE_W-1:0]   rsp_free_ff;
   logic                rsp_dirty_ff;

   // RAM ports
   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   logic [FAT_W-1:0]    ram_wdata;
   logic                ram_re;
   logic [AW-1:0]       ram_raddr;
   logic [FAT_W-1:0]    ram_rdata;

   // helpers
   logic [N_W-1:0]      n_use;
   logic [FAT_W-1:0]    n_ext;
   logic                cl_ok;
   logic [FAT_W-1:0]    start_sel;
   logic [FAT_W:0]      first_inc;
   logic                first_wrap;
   logic                first_empty;
   logic [FAT_W-1:0]    first_cur;
   logic [FAT_W:0]      cur_inc;
   logic                cur_wrap;
   logic [FAT_W-1:0]    scan_next;
   logic                scan_last;
   logic                out_free;

   // n_entries above the table size acts as the table size
   assign n_use = ({4'b0, n_entries_ff} > 17'(MAX_ENTRIES)) ? N_W'(MAX_ENTRIES)
                                                             : n_entries_ff;
   assign n_ext = {3'b0, n_use};
   assign cl_ok = (cl_ff >= 16'd2) && (cl_ff < n_ext);

   // next-fit start: new chains resume after the last hit, extensions after cl
   always_comb begin
      if (cl_ff != '0) begin
         start_sel = cl_ff;
      end else if (last_alloc_ff == '0 || last_alloc_ff >= n_ext) begin
         start_sel = 16'd1;
      end else begin
         start_sel = last_alloc_ff;
      end
   end

   assign first_inc   = {1'b0, start_sel} + 17'd1;
   assign first_wrap  = first_inc >= {4'b0, n_use};
   assign first_empty = first_wrap && (start_sel < 16'd2);
   assign first_cur   = first_wrap ? 16'd2 : first_inc[FAT_W-1:0];

   assign cur_inc   = {1'b0, cur_ff} + 17'd1;
   assign cur_wrap  = cur_inc >= {4'b0, n_use};
   assign scan_next = cur_wrap ? 16'd2 : cur_inc[FAT_W-1:0];
   // a start below 2 scans 2..n-1 once; otherwise the scan ends on start itself
   assign scan_last = (cur_ff == start_ff) || ((start_ff < 16'd2) && cur_wrap);

   assign out_free = !rsp_valid_ff || rsp_ready;

   // RAM port steering
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = clr_ff;
      ram_wdata = '0;
      ram_re    = 1'b0;
      ram_raddr = cur_ff[AW-1:0];
      unique case (state_ff)
         CLEAR: begin
            ram_we = 1'b1;
         end
         DECODE: begin
            ram_waddr = cl_ff[AW-1:0];
            ram_wdata = value_ff;
            ram_raddr = cl_ff[AW-1:0];
            ram_we    = (op_ff == OP_WRITE) && cl_ok;
            ram_re    = ((op_ff == OP_READ) || (op_ff == OP_ALLOC && cl_ff != '0)) && cl_ok;
         end
         SCAN: begin
            ram_re = issue_ff;
         end
         WR_EOC: begin
            ram_we    = 1'b1;
            ram_waddr = found_ff[AW-1:0];
            ram_wdata = END_OF_CHAIN;
         end
         WR_LINK: begin
            ram_we    = 1'b1;
            ram_waddr = cl_ff[AW-1:0];
            ram_wdata = found_ff;
         end
         default: begin
         end
      endcase
   end

   fcca_ram #(
      .WIDTH (FAT_W),
      .DEPTH (MAX_ENTRIES)
   ) u_fat (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= CLEAR;
         clr_ff        <= '0;
         n_entries_ff  <= N_ENTRIES_RESET;
         free_ff       <= FREE_UNKNOWN;
         dirty_ff      <= 1'b0;
         last_alloc_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == AW'(MAX_ENTRIES - 1)) begin
                  state_ff <= IDLE;
               end
            end
            IDLE: begin
               if (req_valid) begin
                  op_ff    <= req_op;
                  cl_ff    <= req_cluster;
                  value_ff <= req_value;
                  state_ff <= DECODE;
               end
            end
            DECODE: begin
               status_ff <= STAT_OK;
               res_ff    <= '0;
               state_ff  <= RESP;
               if (op_ff == OP_READ) begin
                  if (cl_ok) begin
                     state_ff <= RD_WAIT;
                  end else begin
                     status_ff <= STAT_RANGE;
                  end
               end else if (op_ff == OP_WRITE) begin
                  if (!cl_ok) begin
                     status_ff <= STAT_RANGE;
                  end
               end else if (op_ff == OP_ALLOC) begin
                  if (cl_ff != '0) begin
                     if (cl_ok) begin
                        state_ff <= LINK_WAIT;
                     end else begin
                        status_ff <= STAT_RANGE;
                     end
                  end else if (first_empty) begin
                     status_ff <= STAT_FULL;
                  end else begin
                     start_ff <= start_sel;
                     cur_ff   <= first_cur;
                     issue_ff <= 1'b1;
                     pend_ff  <= 1'b0;
                     state_ff <= SCAN;
                  end
               end
            end
            RD_WAIT: begin
               res_ff   <= ram_rdata;
               state_ff <= RESP;
            end
            LINK_WAIT: begin
               state_ff <= RESP;
               if (ram_rdata < 16'd2) begin
                  // chain ends in a free or reserved entry
                  status_ff <= STAT_BAD_LINK;
               end else if (ram_rdata < n_ext) begin
                  res_ff <= ram_rdata;
               end else begin
                  start_ff <= start_sel;
                  cur_ff   <= first_cur;
                  issue_ff <= 1'b1;
                  pend_ff  <= 1'b0;
                  state_ff <= SCAN;
               end
            end
            SCAN: begin
               if (pend_ff && ram_rdata == '0) begin
                  found_ff <= pend_addr_ff;
                  state_ff <= WR_EOC;
               end else if (pend_ff && pend_last_ff) begin
                  status_ff <= STAT_FULL;
                  res_ff    <= '0;
                  state_ff  <= RESP;
               end else begin
                  pend_ff      <= issue_ff;
                  pend_addr_ff <= cur_ff;
                  pend_last_ff <= scan_last;
                  if (issue_ff) begin
                     cur_ff   <= scan_next;
                     issue_ff <= !scan_last;
                  end
               end
            end
            WR_EOC: begin
               last_alloc_ff <= found_ff;
               // unknown count is left alone; a known zero saturates
               if (free_ff != FREE_UNKNOWN) begin
                  if (free_ff != '0) begin
                     free_ff <= free_ff - 17'd1;
                  end
                  dirty_ff <= 1'b1;
               end
               status_ff <= STAT_OK;
               res_ff    <= found_ff;
               state_ff  <= (cl_ff != '0) ? WR_LINK : RESP;
            end
            WR_LINK: begin
               state_ff <= RESP;
            end
            RESP: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_ff;
                  rsp_res_ff    <= res_ff;
                  rsp_free_ff   <= free_ff;
                  rsp_dirty_ff  <= dirty_ff;
                  state_ff      <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase

         // CSR writes must arrive only while idle; the block itself does not enforce it
         if (csr_we) begin
            if (csr_index == REG_N_ENTRIES) begin
               n_entries_ff <= csr_wdata[N_W-1:0];
            end else begin
               free_ff <= (csr_wdata > FREE_UNKNOWN) ? FREE_UNKNOWN : csr_wdata;
            end
         end
      end
   end

   assign req_ready          = (state_ff == IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_result_cluster = rsp_res_ff;
   assign rsp_free_count     = rsp_free_ff;
   assign rsp_info_changed   = rsp_dirty_ff;

endmodule
